// File: hdl/sacl_pkg.sv
// Shared types, constants and the saturating-increment helper of the set-associative LRU lookup block.
package sacl_pkg;

    localparam int MAX_WAYS_DEF  = 8;
    localparam int MAX_LINES_DEF = 1024;
    localparam int ADDR_BITS_DEF = 32;

    localparam int GEOM_LIMIT = 10;
    localparam int SET_W      = 10;
    localparam int WAY_W      = 3;
    localparam int WCNT_W     = 4;
    localparam int DATA_W     = 32;
    localparam int OUT_W      = 72;
    localparam int PADDR_W    = 4;

    localparam logic [DATA_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] REG_WAYS_LOG2   = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    localparam logic [1:0] WAYS_LOG2_RST   = 2'd0;
    localparam logic [3:0] INDEX_BITS_RST  = 4'd5;
    localparam logic [3:0] OFFSET_BITS_RST = 4'd5;

    typedef struct packed {
        logic [1:0] ways_log2;
        logic [3:0] index_bits;
        logic [3:0] offset_bits;
    } sacl_cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BASE,
        ST_SCAN,
        ST_COMMIT,
        ST_FINISH
    } sacl_state_t;

    typedef struct packed {
        logic clear_we;
        logic capture;
        logic base_load;
        logic scan;
        logic issue;
        logic commit;
        logic load_out;
    } sacl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic issue_done;
        logic hit_now;
        logic cmp_valid;
    } sacl_status_t;

    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// File: hdl/set_assoc_cache_lru_lookup_top.sv
// Top level of the set-associative cache tag lookup with LRU replacement.
// After reset the block zeroes all MAX_LINES entries (1024 by default) of the stamp
// memory, with s_tready low; configuration writes are taken during that pass. Each
// address beat is then accepted, the set's first entry is formed, the ways in use
// (one to eight) are scanned through the registered read ports of the tag and stamp
// memories (the scan stops early on a hit), and the stamp is written back, with the
// tag as well on a miss. The result is held in an output register, so the next
// address is accepted while a result beat still waits on m_tready.
module set_assoc_cache_lru_lookup_top import sacl_pkg::*; #(
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // [31:0] address
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,   // [0] hit, [3:1] way_used, [35:4] access_total,
                                          // [67:36] miss_total, [68] time_overflow
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    sacl_cfg_t    cfg_reg;
    sacl_cmd_t    cmd;
    sacl_status_t st;
    logic         cfg_we;
    logic [1:0]   reg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ways_log2   <= WAYS_LOG2_RST;
            cfg_reg.index_bits  <= INDEX_BITS_RST;
            cfg_reg.offset_bits <= OFFSET_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (reg_sel)
                REG_WAYS_LOG2:   cfg_reg.ways_log2   <= pwdata[1:0];
                REG_INDEX_BITS:  cfg_reg.index_bits  <= pwdata[3:0];
                REG_OFFSET_BITS: cfg_reg.offset_bits <= pwdata[3:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WAYS_LOG2:   prdata = {30'd0, cfg_reg.ways_log2};
            REG_INDEX_BITS:  prdata = {28'd0, cfg_reg.index_bits};
            REG_OFFSET_BITS: prdata = {28'd0, cfg_reg.offset_bits};
            default:         prdata = '0;
        endcase
    end

    sacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sacl_dp #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_LINES (MAX_LINES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .st      (st),
        .m_tdata (m_tdata)
    );

endmodule

// File: hdl/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sacl_ctrl.sv
// Controller state machine: clearing pass, lookup sequencing and output handshake.
module sacl_ctrl import sacl_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  sacl_status_t st,
    output sacl_cmd_t    cmd
);

    sacl_state_t state_reg;
    sacl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.base_load = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan  = 1'b1;
                cmd.issue = !st.issue_done && !st.hit_now;
                if (st.hit_now || (st.issue_done && st.cmp_valid))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    // A waiting result is never overwritten by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a beat not yet taken");

    // A hit ends the scan at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && st.hit_now) |=> (state_reg == ST_COMMIT))
        else $error("scan did not stop on hit");

endmodule

// File: hdl/sacl_dp.sv
// Datapath: address split, way scan over the tag and stamp memories, counters and output register.
module sacl_dp import sacl_pkg::*; #(
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sacl_cfg_t         cfg,
    input  logic [DATA_W-1:0] s_tdata,
    input  sacl_cmd_t         cmd,
    output sacl_status_t      st,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int LINE_W    = $clog2(MAX_LINES);
    localparam int RED_STEPS = $clog2((1 << SET_W) / MAX_LINES + 1);
    localparam logic [DATA_W-1:0] ADDR_MASK = (ADDR_BITS >= DATA_W) ? '1 :
        DATA_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_LINES - 1);

    function automatic logic [LINE_W-1:0] line_mod(input logic [SET_W-1:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int k = RED_STEPS - 1; k >= 0; k--)
        begin
            if (r >= (32'(MAX_LINES) << k))
            begin
                r = r - (32'(MAX_LINES) << k);
            end
        end
        return LINE_W'(r);
    endfunction

    // Address split at capture.
    logic [3:0]        ib_clip;
    logic [3:0]        ib_eff;
    logic [DATA_W-1:0] addr_m;
    logic [DATA_W-1:0] shifted;
    logic [SET_W-1:0]  set_cap;
    logic [DATA_W-1:0] tag_cap;
    logic [WCNT_W-1:0] ways_pow;
    logic [WCNT_W-1:0] nways_cap;

    always_comb
    begin
        ib_clip = (cfg.index_bits > 4'(GEOM_LIMIT)) ? 4'(GEOM_LIMIT) : cfg.index_bits;
        ib_eff  = (({2'b00, cfg.ways_log2} + ib_clip) > 4'(GEOM_LIMIT)) ?
                  (4'(GEOM_LIMIT) - {2'b00, cfg.ways_log2}) : ib_clip;
        addr_m  = s_tdata & ADDR_MASK;
        shifted = addr_m >> cfg.offset_bits;
        set_cap = SET_W'(shifted & ((32'd1 << ib_eff) - 32'd1));
        tag_cap = shifted >> ib_eff;
        ways_pow  = WCNT_W'(1) << cfg.ways_log2;
        nways_cap = (int'(ways_pow) > MAX_WAYS) ? WCNT_W'(MAX_WAYS) : ways_pow;
    end

    // Control and state registers.
    logic [DATA_W-1:0] time_reg,   time_next;
    logic [DATA_W-1:0] access_reg, access_next;
    logic [DATA_W-1:0] miss_reg,   miss_next;
    logic              ovf_reg,    ovf_next;
    logic [LINE_W-1:0] clear_addr_reg;
    logic [WCNT_W-1:0] issue_cnt_reg;
    logic [WCNT_W-1:0] nways_reg;
    logic              rd_valid_reg;
    logic              sel_hit_reg;
    logic              free_found_reg;
    logic              min_valid_reg;

    // Payload registers.
    logic [SET_W-1:0]  set_reg;
    logic [1:0]        wl_reg;
    logic [DATA_W-1:0] tag_reg;
    logic [LINE_W-1:0] issue_entry_reg;
    logic [WAY_W-1:0]  cmp_way_reg;
    logic [LINE_W-1:0] cmp_entry_reg;
    logic [WAY_W-1:0]  hit_way_reg;
    logic [LINE_W-1:0] hit_entry_reg;
    logic [WAY_W-1:0]  free_way_reg;
    logic [LINE_W-1:0] free_entry_reg;
    logic [WAY_W-1:0]  min_way_reg;
    logic [LINE_W-1:0] min_entry_reg;
    logic [DATA_W-1:0] min_stamp_reg;
    logic [OUT_W-1:0]  out_reg;

    logic [DATA_W-1:0] tag_rdata;
    logic [DATA_W-1:0] stamp_rdata;
    logic              cmp_en;
    logic              stamp_zero;
    logic              hit_now;
    logic              min_take;
    logic              free_take;
    logic [LINE_W-1:0] entry_inc;
    logic [WAY_W-1:0]  sel_way;
    logic [LINE_W-1:0] sel_entry;
    logic              stamp_we;
    logic [LINE_W-1:0] stamp_waddr;
    logic [DATA_W-1:0] stamp_wdata;

    assign cmp_en     = cmd.scan && rd_valid_reg;
    assign stamp_zero = (stamp_rdata == '0);
    assign hit_now    = cmp_en && !stamp_zero && (tag_rdata == tag_reg);
    assign free_take  = cmp_en && stamp_zero && !free_found_reg;
    assign min_take   = cmp_en && !stamp_zero && !hit_now &&
                        (!min_valid_reg || (stamp_rdata < min_stamp_reg));
    assign entry_inc  = (issue_entry_reg == LINE_LAST) ? '0 : issue_entry_reg + 1'b1;

    always_comb
    begin
        if (sel_hit_reg)
        begin
            sel_way   = hit_way_reg;
            sel_entry = hit_entry_reg;
        end
        else if (free_found_reg)
        begin
            sel_way   = free_way_reg;
            sel_entry = free_entry_reg;
        end
        else
        begin
            sel_way   = min_way_reg;
            sel_entry = min_entry_reg;
        end
    end

    always_comb
    begin
        time_next   = time_reg;
        access_next = access_reg;
        ovf_next    = ovf_reg;
        if (cmd.capture)
        begin
            time_next   = sat_inc(time_reg);
            access_next = sat_inc(access_reg);
            ovf_next    = ovf_reg || (time_next == CNT_MAX);
        end
        miss_next = (cmd.commit && !sel_hit_reg) ? sat_inc(miss_reg) : miss_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            access_reg     <= '0;
            miss_reg       <= '0;
            ovf_reg        <= 1'b0;
            clear_addr_reg <= '0;
            issue_cnt_reg  <= '0;
            nways_reg      <= WCNT_W'(1);
            rd_valid_reg   <= 1'b0;
            sel_hit_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            min_valid_reg  <= 1'b0;
        end
        else
        begin
            time_reg   <= time_next;
            access_reg <= access_next;
            miss_reg   <= miss_next;
            ovf_reg    <= ovf_next;
            if (cmd.clear_we)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
            if (cmd.capture)
            begin
                nways_reg <= nways_cap;
            end
            if (cmd.base_load)
            begin
                issue_cnt_reg  <= '0;
                rd_valid_reg   <= 1'b0;
                sel_hit_reg    <= 1'b0;
                free_found_reg <= 1'b0;
                min_valid_reg  <= 1'b0;
            end
            else
            begin
                rd_valid_reg <= cmd.issue;
                if (cmd.issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (hit_now)
                begin
                    sel_hit_reg <= 1'b1;
                end
                if (free_take)
                begin
                    free_found_reg <= 1'b1;
                end
                if (min_take)
                begin
                    min_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            set_reg <= set_cap;
            wl_reg  <= cfg.ways_log2;
            tag_reg <= tag_cap;
        end
        if (cmd.base_load)
        begin
            issue_entry_reg <= line_mod(SET_W'(set_reg << wl_reg));
        end
        else if (cmd.issue)
        begin
            issue_entry_reg <= entry_inc;
        end
        if (cmd.issue)
        begin
            cmp_way_reg   <= issue_cnt_reg[WAY_W-1:0];
            cmp_entry_reg <= issue_entry_reg;
        end
        if (hit_now)
        begin
            hit_way_reg   <= cmp_way_reg;
            hit_entry_reg <= cmp_entry_reg;
        end
        if (free_take)
        begin
            free_way_reg   <= cmp_way_reg;
            free_entry_reg <= cmp_entry_reg;
        end
        if (min_take)
        begin
            min_way_reg   <= cmp_way_reg;
            min_entry_reg <= cmp_entry_reg;
            min_stamp_reg <= stamp_rdata;
        end
        if (cmd.load_out)
        begin
            out_reg <= {3'b000, ovf_reg, miss_next, access_reg, sel_way, sel_hit_reg};
        end
    end

    assign stamp_we    = cmd.clear_we || cmd.commit;
    assign stamp_waddr = cmd.clear_we ? clear_addr_reg : sel_entry;
    assign stamp_wdata = cmd.clear_we ? '0 : time_reg;

    sacl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (cmd.commit && !sel_hit_reg),
        .waddr (sel_entry),
        .wdata (tag_reg),
        .re    (cmd.issue),
        .raddr (issue_entry_reg),
        .rdata (tag_rdata)
    );

    sacl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LINES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (stamp_wdata),
        .re    (cmd.issue),
        .raddr (issue_entry_reg),
        .rdata (stamp_rdata)
    );

    assign st.clear_last = (clear_addr_reg == LINE_LAST);
    assign st.issue_done = (issue_cnt_reg == nways_reg);
    assign st.hit_now    = hit_now;
    assign st.cmp_valid  = rd_valid_reg;
    assign m_tdata       = out_reg;

    // The committed way must come from a hit, a free way or a valid oldest way.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (sel_hit_reg || free_found_reg || min_valid_reg))
        else $error("commit without a selected way");

    // The scan never reads past the ways of the set.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (issue_cnt_reg <= nways_reg))
        else $error("way scan ran past the set");

    // The time overflow flag stays set once raised.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("sticky overflow flag cleared");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the set-associative cache tag lookup with LRU replacement.
`timescale 1ns / 100ps

module tb_top import sacl_pkg::*; ();

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int LINE_COUNT = 1024;

    typedef struct packed {
        logic        overflow;
        logic [31:0] miss_total;
        logic [31:0] access_total;
        logic [2:0]  way;
        logic        hit;
    } lookup_res_t;

    typedef struct {
        logic [1:0]  wl;
        logic [3:0]  ib;
        logic [3:0]  ob;
        logic [31:0] addr;
        bit          typed;
        logic        hit;
        logic [2:0]  way;
        logic [31:0] acc;
        logic [31:0] mis;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic [1:0]  geo_wl = WAYS_LOG2_RST;
    logic [3:0]  geo_ib = INDEX_BITS_RST;
    logic [3:0]  geo_ob = OFFSET_BITS_RST;
    logic [31:0] tag_mem [LINE_COUNT];
    logic [31:0] stamp_mem [LINE_COUNT];
    logic [31:0] lru_clock = '0;
    logic [31:0] access_cnt = '0;
    logic [31:0] miss_cnt = '0;
    logic        clock_sat = 1'b0;

    lookup_res_t expected_lookups[$];
    bit          gaps_on = 1'b1;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          lookups_sent = 0;
    int          hits_seen = 0;
    int          misses_seen = 0;
    int          geometry_cnt = 1;

    dir_row_t dir_rows [25] = '{
        '{2'd0, 4'd5, 4'd5, 32'h0000_0000, 1'b1, 1'b0, 3'd0, 32'd1, 32'd1},
        '{2'd0, 4'd5, 4'd5, 32'h0000_0000, 1'b1, 1'b1, 3'd0, 32'd2, 32'd1},
        '{2'd0, 4'd5, 4'd5, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'd0, 32'd3, 32'd2},
        '{2'd0, 4'd5, 4'd5, 32'hFFFF_FFE0, 1'b1, 1'b1, 3'd0, 32'd4, 32'd2},
        '{2'd0, 4'd5, 4'd5, 32'h0000_001F, 1'b1, 1'b1, 3'd0, 32'd5, 32'd2},
        '{2'd0, 4'd5, 4'd5, 32'h0000_0400, 1'b1, 1'b0, 3'd0, 32'd6, 32'd3},
        '{2'd0, 4'd5, 4'd5, 32'h0000_0000, 1'b1, 1'b0, 3'd0, 32'd7, 32'd4},
        '{2'd3, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0001, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0002, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0003, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0004, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0005, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0006, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h8000_0000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0001, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd0, 4'd0, 32'h0000_0007, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd2, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd2, 4'd15, 4'd15, 32'h0000_7FFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd2, 4'd15, 4'd15, 32'h00FF_8000, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd2, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd10, 4'd8, 32'h0000_FF00, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd10, 4'd8, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0},
        '{2'd3, 4'd10, 4'd8, 32'h0000_FF00, 1'b0, 1'b0, 3'd0, 32'd0, 32'd0}
    };

    set_assoc_cache_lru_lookup_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    initial
    begin
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            tag_mem[i] = '0;
            stamp_mem[i] = '0;
        end
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic int unsigned usable_index_bits(input logic [1:0] wl,
                                                      input logic [3:0] ib);
        int unsigned n;
        n = (ib > 10) ? 10 : ib;
        if (wl + n > 10)
            n = 10 - wl;
        return n;
    endfunction

    function automatic lookup_res_t cache_lookup(input logic [31:0] addr);
        int unsigned nways;
        int unsigned ib;
        int unsigned set_no;
        int unsigned e;
        int unsigned way;
        logic [31:0] tag;
        logic [31:0] best;
        bit          found;
        lookup_res_t r;
        nways = 1 << geo_wl;
        if (nways > 8)
            nways = 8;
        ib = usable_index_bits(geo_wl, geo_ib);
        set_no = (addr >> geo_ob) & ((32'd1 << ib) - 1);
        tag = addr >> (geo_ob + ib);
        access_cnt = bump(access_cnt);
        lru_clock = bump(lru_clock);
        if (lru_clock == '1)
            clock_sat = 1'b1;
        found = 1'b0;
        way = 0;
        best = '0;
        for (int unsigned w = 0; w < nways; w++)
        begin
            e = (set_no * nways + w) % LINE_COUNT;
            if (stamp_mem[e] != 0 && tag_mem[e] == tag)
            begin
                stamp_mem[e] = lru_clock;
                way = w;
                found = 1'b1;
                break;
            end
        end
        if (!found)
        begin
            miss_cnt = bump(miss_cnt);
            for (int unsigned w = 0; w < nways; w++)
            begin
                e = (set_no * nways + w) % LINE_COUNT;
                if (stamp_mem[e] == 0)
                begin
                    way = w;
                    break;
                end
                if (w == 0 || stamp_mem[e] < best)
                begin
                    best = stamp_mem[e];
                    way = w;
                end
            end
            e = (set_no * nways + way) % LINE_COUNT;
            stamp_mem[e] = lru_clock;
            tag_mem[e] = tag;
        end
        r.hit = found;
        r.way = way[2:0];
        r.access_total = access_cnt;
        r.miss_total = miss_cnt;
        r.overflow = clock_sat;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_WAYS_LOG2:   geo_wl = val[1:0];
            REG_INDEX_BITS:  geo_ib = val[3:0];
            REG_OFFSET_BITS: geo_ob = val[3:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== val)
            flag_error($sformatf("register %0d readback: expected %0h, got %0h", idx, val, rd));
    endtask

    task automatic set_geometry(input logic [1:0] wl, input logic [3:0] ib,
                                input logic [3:0] ob);
        s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_WAYS_LOG2, {30'd0, wl});
        write_reg(REG_INDEX_BITS, {28'd0, ib});
        write_reg(REG_OFFSET_BITS, {28'd0, ob});
        geometry_cnt++;
    endtask

    task automatic push_address(input logic [31:0] addr, input bit typed,
                                input lookup_res_t typed_res);
        lookup_res_t r;
        if (gaps_on && $urandom_range(0, 99) < 21)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 21);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        do @(posedge clk); while (!s_tready);
        r = cache_lookup(addr);
        expected_lookups.push_back(typed ? typed_res : r);
        lookups_sent++;
    endtask

    always @(posedge clk)
    begin
        m_tready <= gaps_on ? ($urandom_range(0, 99) >= 21) : 1'b1;
    end

    always @(posedge clk)
    begin
        lookup_res_t exp_r;
        lookup_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[68:0];
            if (got.hit)
                hits_seen++;
            else
                misses_seen++;
            if (expected_lookups.size() == 0)
                flag_error($sformatf("result beat with nothing expected: %0h", got));
            else
            begin
                exp_r = expected_lookups.pop_front();
                if (got.hit !== exp_r.hit)
                    flag_error($sformatf("hit: expected %0d, got %0d", exp_r.hit, got.hit));
                if (got.way !== exp_r.way)
                    flag_error($sformatf("way_used: expected %0d, got %0d",
                                         exp_r.way, got.way));
                if (got.access_total !== exp_r.access_total)
                    flag_error($sformatf("access_total: expected %0d, got %0d",
                                         exp_r.access_total, got.access_total));
                if (got.miss_total !== exp_r.miss_total)
                    flag_error($sformatf("miss_total: expected %0d, got %0d",
                                         exp_r.miss_total, got.miss_total));
                if (got.overflow !== exp_r.overflow)
                    flag_error($sformatf("time_overflow: expected %0d, got %0d",
                                         exp_r.overflow, got.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_cnt, expected_lookups.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        lookup_res_t typed_res;
        logic [1:0]  wl;
        logic [3:0]  ib;
        logic [3:0]  ob;
        logic [31:0] tag_pool [12];
        logic [31:0] addr;
        int unsigned ibits;
        int unsigned pool_n;
        int unsigned set_top;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wl != geo_wl || dir_rows[i].ib != geo_ib ||
                dir_rows[i].ob != geo_ob)
                set_geometry(dir_rows[i].wl, dir_rows[i].ib, dir_rows[i].ob);
            typed_res.hit = dir_rows[i].hit;
            typed_res.way = dir_rows[i].way;
            typed_res.access_total = dir_rows[i].acc;
            typed_res.miss_total = dir_rows[i].mis;
            typed_res.overflow = 1'b0;
            push_address(dir_rows[i].addr, dir_rows[i].typed, typed_res);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin wl = 2'd0; ib = 4'd0; ob = 4'd0; end
                1: begin wl = 2'd3; ib = 4'd15; ob = 4'd15; end
                2: begin wl = 2'd3; ib = 4'd10; ob = 4'd0; end
                3: begin wl = 2'd2; ib = 4'd3; ob = 4'd2; end
                4: begin wl = 2'd1; ib = 4'd10; ob = 4'd8; end
                default:
                begin
                    wl = $urandom_range(0, 3);
                    ib = $urandom_range(0, 15);
                    ob = $urandom_range(0, 15);
                end
            endcase
            set_geometry(wl, ib, ob);
            gaps_on = !(p == 2 || p == 3);
            ibits = usable_index_bits(wl, ib);
            pool_n = (1 << wl) + 2;
            set_top = ((1 << ibits) - 1 < 3) ? (1 << ibits) - 1 : 3;
            foreach (tag_pool[k])
                tag_pool[k] = $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                    addr = $urandom;
                else
                    addr = (tag_pool[$urandom_range(0, pool_n - 1)] << (ob + ibits)) |
                           ($urandom_range(0, set_top) << ob) |
                           ($urandom & ((32'd1 << ob) - 1));
                push_address(addr, 1'b0, typed_res);
            end
        end
        gaps_on = 1'b1;

        s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d address lookups over %0d cache geometries: %0d hits, %0d misses.",
                 lookups_sent, geometry_cnt, hits_seen, misses_seen);
        if (mismatch_cnt == 0 && expected_lookups.size() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches, %0d results missing.", mismatch_cnt,
                     expected_lookups.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
